FILE: rtl/rational_normalizer_macros.svh
// Assertion macros for the rational normaliser RTL.
`ifndef RATIONAL_NORMALIZER_MACROS_SVH
`define RATIONAL_NORMALIZER_MACROS_SVH
`ifndef SYNTHESIS
`define RN_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define RN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RN_ASSERT_SAME(lbl, ante, cons, msg)
`define RN_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/rn_pkg.sv
// Types shared by the rational normaliser modules.
package rn_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_SHIFT,
    ST_DIV_NUM,
    ST_DIV_DEN,
    ST_DONE
  } rn_state_t;

  typedef struct packed {
    logic idle;
    logic done;
  } rn_status_t;

endpackage

FILE: rtl/rational_normalizer.sv
// A zero numerator goes from the input transfer straight to the done state. Any other input
// runs the binary GCD loop, the shift back of common factors of two and two restoring
// divisions of DATA_WIDTH-1 steps each, all on one subtractor.
// Only one item is in work at a time; the next transfer can be taken in the cycle after the
// result enters the output register, so a waiting result does not hold up the core.
// Synchronous reset returns the sequencer to idle and empties the output register.
`include "rational_normalizer_macros.svh"

module rational_normalizer
  import rn_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic signed [DATA_WIDTH-1:0] num_in,
  input  logic signed [DATA_WIDTH-1:0] den_in,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic signed [DATA_WIDTH-1:0] num_out,
  output logic [DATA_WIDTH-2:0]        den_out,
  output logic                         invalid
);

  localparam logic [DATA_WIDTH-2:0] DEN_ONE = (DATA_WIDTH-1)'(1);

  rn_status_t            status;
  logic [DATA_WIDTH-2:0] qn, qd;
  logic                  sgn, inv;
  logic                  start, take;
  logic [DATA_WIDTH-1:0] num_mag;

  // No transfer is taken while reset is held.
  assign req_stall = rst || !status.idle;
  assign start     = req_valid && !req_stall;
  assign take      = status.done && (!rsp_valid || !rsp_stall);
  assign num_mag   = {1'b0, qn};

  rn_core #(.DATA_WIDTH(DATA_WIDTH)) u_core (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .num_in (num_in),
    .den_in (den_in),
    .take   (take),
    .status (status),
    .qn     (qn),
    .qd     (qd),
    .sgn    (sgn),
    .inv    (inv)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      num_out <= sgn ? -num_mag : num_mag;
      den_out <= qd;
      invalid <= inv;
    end
  end

  `RN_ASSERT_SAME(a_invalid_zero, rsp_valid && invalid, num_out == '0 && den_out == DEN_ONE, "not 0/1")
  `RN_ASSERT_NEXT(a_busy_after_start, req_valid && !req_stall, req_stall, "idle after transfer")
  `RN_ASSERT_NEXT(a_result_loaded, status.done && !rsp_valid, rsp_valid, "result not loaded")

endmodule

FILE: rtl/rn_sub.sv
// Shared subtractor and magnitude comparator used by the GCD and division steps of the core.
module rn_sub #(
  parameter int WIDTH = 32
) (
  input  logic [WIDTH-1:0] x,
  input  logic [WIDTH-1:0] y,
  output logic [WIDTH-1:0] diff,
  output logic             borrow
);

  assign {borrow, diff} = {1'b0, x} - {1'b0, y};

endmodule

FILE: rtl/rn_core.sv
// Sequencer for binary GCD and two restoring divisions over one subtractor.
module rn_core
  import rn_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [DATA_WIDTH-1:0] num_in,
  input  logic signed [DATA_WIDTH-1:0] den_in,
  input  logic                         take,
  output rn_status_t                   status,
  output logic [DATA_WIDTH-2:0]        qn,
  output logic [DATA_WIDTH-2:0]        qd,
  output logic                         sgn,
  output logic                         inv
);

  localparam int M  = DATA_WIDTH - 1;
  localparam int CW = $clog2(M);

  rn_state_t state, state_next;

  logic [M-1:0]  a, a_next, b, b_next;
  logic [M-1:0]  nmag, nmag_next, dmag, dmag_next;
  logic [M-1:0]  dq, dq_next, rem, rem_next;
  logic [M-1:0]  qn_next, qd_next;
  logic [CW-1:0] k, k_next, cnt, cnt_next;
  logic          sgn_next, inv_next;

  logic [M:0]    sub_x, sub_y, diff;
  logic          borrow;

  logic [DATA_WIDTH-1:0] num_neg, den_neg;
  logic [M-1:0]          nmag_in, dmag_in;

  rn_sub #(.WIDTH(M + 1)) u_sub (
    .x      (sub_x),
    .y      (sub_y),
    .diff   (diff),
    .borrow (borrow)
  );

  // The most negative input saturates to the largest positive magnitude.
  assign num_neg = -num_in;
  assign den_neg = -den_in;
  assign nmag_in = num_in[M] ? (num_neg[M] ? {M{1'b1}} : num_neg[M-1:0]) : num_in[M-1:0];
  assign dmag_in = den_in[M] ? (den_neg[M] ? {M{1'b1}} : den_neg[M-1:0]) : den_in[M-1:0];

  assign status.idle = (state == ST_IDLE);
  assign status.done = (state == ST_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    a    <= a_next;
    b    <= b_next;
    k    <= k_next;
    nmag <= nmag_next;
    dmag <= dmag_next;
    dq   <= dq_next;
    rem  <= rem_next;
    cnt  <= cnt_next;
    qn   <= qn_next;
    qd   <= qd_next;
    sgn  <= sgn_next;
    inv  <= inv_next;
  end

  always_comb begin
    state_next = state;
    a_next     = a;
    b_next     = b;
    k_next     = k;
    nmag_next  = nmag;
    dmag_next  = dmag;
    dq_next    = dq;
    rem_next   = rem;
    cnt_next   = cnt;
    qn_next    = qn;
    qd_next    = qd;
    sgn_next   = sgn;
    inv_next   = inv;
    sub_x      = {1'b0, a};
    sub_y      = {1'b0, b};
    case (state)
      ST_IDLE: begin
        if (start) begin
          nmag_next = nmag_in;
          dmag_next = dmag_in;
          // b holds the nonzero numerator so that it never reaches zero.
          a_next    = dmag_in;
          b_next    = nmag_in;
          k_next    = '0;
          sgn_next  = num_in[M] ^ den_in[M];
          inv_next  = 1'b0;
          if (nmag_in == '0) begin
            qn_next    = '0;
            qd_next    = M'(1);
            sgn_next   = 1'b0;
            inv_next   = (dmag_in == '0);
            state_next = ST_DONE;
          end else begin
            state_next = ST_GCD;
          end
        end
      end
      ST_GCD: begin
        if (a == '0) begin
          state_next = ST_SHIFT;
        end else if (!a[0] && !b[0]) begin
          a_next = {1'b0, a[M-1:1]};
          b_next = {1'b0, b[M-1:1]};
          k_next = k + 1'b1;
        end else if (!a[0]) begin
          a_next = {1'b0, a[M-1:1]};
        end else if (!b[0]) begin
          b_next = {1'b0, b[M-1:1]};
        end else if (!borrow) begin
          a_next = diff[M:1];
        end else begin
          a_next = b;
          b_next = a;
        end
      end
      ST_SHIFT: begin
        if (k == '0) begin
          dq_next    = nmag;
          rem_next   = '0;
          cnt_next   = CW'(M - 1);
          state_next = ST_DIV_NUM;
        end else begin
          b_next = {b[M-2:0], 1'b0};
          k_next = k - 1'b1;
        end
      end
      ST_DIV_NUM, ST_DIV_DEN: begin
        sub_x    = {rem, dq[M-1]};
        sub_y    = {1'b0, b};
        rem_next = borrow ? sub_x[M-1:0] : diff[M-1:0];
        dq_next  = {dq[M-2:0], ~borrow};
        cnt_next = cnt - 1'b1;
        if (cnt == '0) begin
          if (state == ST_DIV_NUM) begin
            qn_next    = {dq[M-2:0], ~borrow};
            dq_next    = dmag;
            rem_next   = '0;
            cnt_next   = CW'(M - 1);
            state_next = ST_DIV_DEN;
          end else begin
            qd_next    = {dq[M-2:0], ~borrow};
            state_next = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (take) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
